>>> src/scpr_pkg.sv
package scpr_pkg;

    // Queue and page space dimensions
    localparam int QUEUE_DEPTH = 32;
    localparam int PAGE_COUNT  = 1024;

    localparam int PAGE_W     = 10;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int REF_AW     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int PAGE_CMP_W = 17;

    // Request kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_REF   = 2'd1;
    localparam logic [1:0] KIND_EVICT = 2'd2;
    localparam logic [1:0] KIND_POP   = 2'd3;

    // Result actions
    localparam logic [2:0] ACT_ADDED      = 3'd0;
    localparam logic [2:0] ACT_FULL       = 3'd1;
    localparam logic [2:0] ACT_REFERENCED = 3'd2;
    localparam logic [2:0] ACT_UNMAP      = 3'd3;
    localparam logic [2:0] ACT_VICTIM     = 3'd4;
    localparam logic [2:0] ACT_EMPTY      = 3'd5;
    localparam logic [2:0] ACT_POPPED     = 3'd6;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PAGE_W-1:0] page_id;
        logic              ref_on_add;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        action;
        logic [PAGE_W-1:0] page_out;
        logic              last;
    } t_out_item;

endpackage

>>> src/scpr_ram.sv
module scpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read enable
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/second_chance_page_replacer_unit.sv
// Second-chance page replacement queue. Resident page numbers sit in a ring
// memory of QUEUE_DEPTH entries, and one reference bit per page number sits
// in a second memory of PAGE_COUNT one-bit entries. After reset the block
// sweeps the reference-bit memory to zero, one entry a cycle, so o_in_ready
// stays low until the sweep is done. Requests are handled one at a time: add,
// reference, and any request on an empty queue yield their result from the
// execute state; pop first reads the head page from the ring. Evict reads the
// head page and then its reference bit, and requeues k second-chance pages at
// the tail before it finds the victim; each such visit costs a ring read,
// a reference-bit read that depends on the page just read, and a write-back,
// all through the single read port of each memory. An evict produces k unmap
// results followed by one victim result, and last marks the final result of
// every request. The result register lets the next request transfer in while
// the final result still waits downstream.
module second_chance_page_replacer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  scpr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output scpr_pkg::t_out_item o_out_data
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_EXEC     = 3'd2;
    localparam logic [2:0] ST_POP      = 3'd3;
    localparam logic [2:0] ST_EV_PAGE  = 3'd4;
    localparam logic [2:0] ST_EV_BIT   = 3'd5;
    localparam logic [2:0] ST_EV_FETCH = 3'd6;

    localparam logic [scpr_pkg::QPTR_W-1:0] QPTR_LAST =
        scpr_pkg::QPTR_W'(scpr_pkg::QUEUE_DEPTH - 1);
    localparam logic [scpr_pkg::OCC_W-1:0] OCC_FULL =
        scpr_pkg::OCC_W'(scpr_pkg::QUEUE_DEPTH);
    localparam logic [scpr_pkg::REF_AW-1:0] CLR_LAST =
        scpr_pkg::REF_AW'(scpr_pkg::PAGE_COUNT - 1);
    localparam logic [scpr_pkg::PAGE_CMP_W-1:0] PAGE_LIMIT =
        scpr_pkg::PAGE_CMP_W'(scpr_pkg::PAGE_COUNT);

    logic [2:0]                    r_state, n_state;
    scpr_pkg::t_in_item            r_item, n_item;
    logic [scpr_pkg::QPTR_W-1:0]   r_head, n_head;
    logic [scpr_pkg::QPTR_W-1:0]   r_tail, n_tail;
    logic [scpr_pkg::OCC_W-1:0]    r_occ, n_occ;
    logic [scpr_pkg::REF_AW-1:0]   r_clr, n_clr;
    logic                          r_out_valid, n_out_valid;
    scpr_pkg::t_out_item           r_out, n_out;

    // Ring memory port
    logic                          f_we, f_re;
    logic [scpr_pkg::QPTR_W-1:0]   f_waddr, f_raddr;
    logic [scpr_pkg::PAGE_W-1:0]   f_wdata, f_rdata;

    // Reference-bit memory port
    logic                          b_we, b_re;
    logic [scpr_pkg::REF_AW-1:0]   b_waddr, b_raddr;
    logic                          b_wdata, b_rdata;

    logic                          out_free;
    logic [scpr_pkg::QPTR_W-1:0]   head_next, tail_next;
    logic [scpr_pkg::PAGE_CMP_W-1:0] item_ext, pg_ext;
    logic                          item_in_range, pg_in_range;
    logic [scpr_pkg::REF_AW-1:0]   item_addr, pg_addr;

    scpr_ram #(
        .WIDTH (scpr_pkg::PAGE_W),
        .DEPTH (scpr_pkg::QUEUE_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    scpr_ram #(
        .WIDTH (1),
        .DEPTH (scpr_pkg::PAGE_COUNT)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (b_re),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // A new result may load when the register is empty or draining this cycle
    assign out_free  = !r_out_valid || i_out_ready;
    assign head_next = (r_head == QPTR_LAST) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == QPTR_LAST) ? '0 : r_tail + 1'b1;

    // Page numbers beyond the bit memory read as clear and drop writes
    assign item_ext      = scpr_pkg::PAGE_CMP_W'(r_item.page_id);
    assign item_in_range = item_ext < PAGE_LIMIT;
    assign item_addr     = item_ext[scpr_pkg::REF_AW-1:0];
    assign pg_ext        = scpr_pkg::PAGE_CMP_W'(f_rdata);
    assign pg_in_range   = pg_ext < PAGE_LIMIT;
    assign pg_addr       = pg_ext[scpr_pkg::REF_AW-1:0];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        n_clr   = r_clr;
        n_out   = r_out;
        n_out_valid = (r_out_valid && !i_out_ready);

        f_we    = 1'b0;
        f_waddr = r_tail;
        f_wdata = r_item.page_id;
        f_re    = 1'b0;
        f_raddr = r_head;
        b_we    = 1'b0;
        b_waddr = item_addr;
        b_wdata = 1'b0;
        b_re    = 1'b0;
        b_raddr = pg_addr;

        case (r_state)
            ST_CLEAR: begin
                // Sweep the reference bits to zero
                b_we    = 1'b1;
                b_waddr = r_clr;
                b_wdata = 1'b0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                case (r_item.kind)
                    scpr_pkg::KIND_ADD: begin
                        if (out_free) begin
                            n_out_valid     = 1'b1;
                            n_out.page_out  = r_item.page_id;
                            n_out.last      = 1'b1;
                            n_state         = ST_IDLE;
                            if (r_occ == OCC_FULL) begin
                                n_out.action = scpr_pkg::ACT_FULL;
                            end else begin
                                n_out.action = scpr_pkg::ACT_ADDED;
                                f_we    = 1'b1;
                                b_we    = item_in_range;
                                b_wdata = r_item.ref_on_add;
                                n_tail  = tail_next;
                                n_occ   = r_occ + 1'b1;
                            end
                        end
                    end
                    scpr_pkg::KIND_REF: begin
                        if (out_free) begin
                            b_we           = item_in_range;
                            b_wdata        = 1'b1;
                            n_out_valid    = 1'b1;
                            n_out.action   = scpr_pkg::ACT_REFERENCED;
                            n_out.page_out = r_item.page_id;
                            n_out.last     = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end
                    default: begin
                        // Evict and pop share the empty check and head read
                        if (r_occ == '0) begin
                            if (out_free) begin
                                n_out_valid    = 1'b1;
                                n_out.action   = scpr_pkg::ACT_EMPTY;
                                n_out.page_out = '0;
                                n_out.last     = 1'b1;
                                n_state        = ST_IDLE;
                            end
                        end else begin
                            f_re    = 1'b1;
                            n_state = (r_item.kind == scpr_pkg::KIND_POP) ?
                                      ST_POP : ST_EV_PAGE;
                        end
                    end
                endcase
            end

            ST_POP: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.action   = scpr_pkg::ACT_POPPED;
                    n_out.page_out = f_rdata;
                    n_out.last     = 1'b1;
                    n_head         = head_next;
                    n_occ          = r_occ - 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            ST_EV_PAGE: begin
                // Fetch the reference bit of the head page
                b_re    = 1'b1;
                n_state = ST_EV_BIT;
            end

            ST_EV_BIT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.page_out = f_rdata;
                    n_head         = head_next;
                    if (pg_in_range && b_rdata) begin
                        // Second chance: clear the bit, requeue at the tail
                        n_out.action = scpr_pkg::ACT_UNMAP;
                        n_out.last   = 1'b0;
                        b_we         = 1'b1;
                        b_waddr      = pg_addr;
                        b_wdata      = 1'b0;
                        f_we         = 1'b1;
                        f_wdata      = f_rdata;
                        n_tail       = tail_next;
                        n_state      = ST_EV_FETCH;
                    end else begin
                        n_out.action = scpr_pkg::ACT_VICTIM;
                        n_out.last   = 1'b1;
                        n_occ        = r_occ - 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end

            ST_EV_FETCH: begin
                // Read the new head after the requeue write has landed
                f_re    = 1'b1;
                n_state = ST_EV_PAGE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

endmodule

>>> src/scpr_checker.sv
module scpr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input scpr_pkg::t_in_item  i_in_data,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input scpr_pkg::t_out_item i_out_data
);

    // Result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Only an unmap leaves more results of the same request to follow
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            ((i_out_data.action == scpr_pkg::ACT_UNMAP) == !i_out_data.last))
        else $error("last flag does not match action");

    // Empty status carries page zero
    a_empty_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.action == scpr_pkg::ACT_EMPTY |->
            i_out_data.page_out == '0)
        else $error("empty status with nonzero page");

    // One request in flight: ready drops after a transfer in
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in flight");

    // Added, referenced and full results echo the requested page
    a_echo_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_data.kind != scpr_pkg::KIND_EVICT &&
        i_in_data.kind != scpr_pkg::KIND_POP ##1 !i_out_valid |=>
            i_out_valid && i_out_data.page_out == $past(i_in_data.page_id, 2))
        else $error("result page differs from requested page");

endmodule

bind second_chance_page_replacer_unit scpr_checker u_scpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
